### rtl/colormap_interpolator_top_macros.svh
// Assertion macros for the colormap interpolator checker.
// Depends on a clock i_clk and a synchronous active-low reset i_rst_n in scope.
`ifndef COLORMAP_INTERPOLATOR_TOP_MACROS_SVH
`define COLORMAP_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication
`define CMI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cmi_pkg.sv
// Shared types, constants and colormap stop tables for the colormap interpolator.
// No dependencies.
package cmi_pkg;

    localparam int MAP_COUNT       = 10;
    localparam int STOP_MAX        = 11;
    localparam int CH_COUNT        = 3;
    localparam int POS_SCALE       = 1000;
    localparam int LEVEL_COUNT_DEF = 256;
    localparam int QUO_BITS        = 8;
    localparam int PIPE_DEPTH      = 13;

    typedef logic [3:0] t_map_idx;
    typedef logic [3:0] t_stop_idx;
    typedef logic [9:0] t_pos;
    typedef logic [7:0] t_chan;
    typedef t_chan [CH_COUNT-1:0] t_rgb;

    typedef struct packed {
        t_rgb ca;
        t_rgb cb;
    } t_col_pair;

    localparam t_map_idx MAP_PARULA = 4'd0;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int MAP_LEN [MAP_COUNT] = '{9, 9, 11, 9, 4, 2, 4, 2, 6, 6};

    // unused tail entries repeat the top stop
    localparam int POS_ROM [MAP_COUNT][STOP_MAX] = '{
        '{0, 125, 250, 375, 500, 625, 750, 875, 1000, 1000, 1000},
        '{0, 125, 250, 375, 500, 625, 750, 875, 1000, 1000, 1000},
        '{0, 100, 200, 300, 400, 500, 600, 700, 800, 900, 1000},
        '{0, 125, 250, 375, 500, 625, 750, 875, 1000, 1000, 1000},
        '{0, 375, 750, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000},
        '{0, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000},
        '{0, 375, 750, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000},
        '{0, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000},
        '{0, 150, 350, 600, 820, 1000, 1000, 1000, 1000, 1000, 1000},
        '{0, 150, 350, 600, 820, 1000, 1000, 1000, 1000, 1000, 1000}
    };

    localparam int R_ROM [MAP_COUNT][STOP_MAX] = '{
        '{53, 15, 5, 24, 85, 158, 220, 251, 249, 249, 249},
        '{0, 0, 0, 0, 127, 255, 255, 255, 127, 127, 127},
        '{48, 70, 62, 24, 70, 162, 225, 254, 239, 189, 122},
        '{68, 71, 59, 44, 33, 39, 92, 170, 253, 253, 253},
        '{0, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255},
        '{0, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255},
        '{0, 81, 166, 255, 255, 255, 255, 255, 255, 255, 255},
        '{0, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255},
        '{2, 6, 16, 40, 118, 224, 224, 224, 224, 224, 224},
        '{4, 36, 92, 168, 232, 255, 255, 255, 255, 255, 255}
    };

    localparam int G_ROM [MAP_COUNT][STOP_MAX] = '{
        '{42, 92, 125, 149, 165, 174, 182, 205, 251, 251, 251},
        '{0, 0, 127, 255, 255, 255, 127, 0, 0, 0, 0},
        '{18, 107, 155, 214, 248, 252, 220, 163, 89, 32, 4},
        '{1, 44, 81, 113, 144, 173, 200, 220, 231, 231, 231},
        '{0, 0, 255, 255, 255, 255, 255, 255, 255, 255, 255},
        '{0, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255},
        '{0, 81, 198, 255, 255, 255, 255, 255, 255, 255, 255},
        '{255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{6, 32, 86, 168, 232, 255, 255, 255, 255, 255, 255},
        '{3, 20, 50, 102, 170, 236, 236, 236, 236, 236, 236}
    };

    localparam int B_ROM [MAP_COUNT][STOP_MAX] = '{
        '{135, 221, 205, 174, 130, 91, 63, 40, 14, 14, 14},
        '{143, 255, 255, 255, 127, 0, 0, 0, 0, 0, 0},
        '{59, 227, 254, 203, 131, 60, 55, 49, 17, 4, 3},
        '{84, 122, 139, 142, 141, 129, 99, 50, 37, 37, 37},
        '{0, 0, 0, 255, 255, 255, 255, 255, 255, 255, 255},
        '{0, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255},
        '{0, 113, 198, 255, 255, 255, 255, 255, 255, 255, 255},
        '{255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255},
        '{4, 16, 38, 72, 132, 228, 228, 228, 228, 228, 228},
        '{2, 4, 6, 14, 58, 196, 196, 196, 196, 196, 196}
    };

    function automatic t_rgb stop_rgb(t_map_idx m, t_stop_idx j);
        t_rgb c;
        c[CH_RED]   = t_chan'(R_ROM[m][j]);
        c[CH_GREEN] = t_chan'(G_ROM[m][j]);
        c[CH_BLUE]  = t_chan'(B_ROM[m][j]);
        return c;
    endfunction

endpackage

### rtl/colormap_interpolator_top.sv
// Colormap interpolator top level: map_select register and the 13-stage
// pipeline. Depends on cmi_pkg, cmi_seg_select, cmi_lerp_mul, cmi_div_pipe.
//
//  channel   valid        ready         payload
//  -------   -----------  ------------  ------------------------------
//  input     i_valid      o_ready       i_level[7:0]
//  result    o_valid      i_ready       o_red, o_green, o_blue [7:0]
//  config    i_cfg_valid  o_cfg_ready   i_map_select[3:0]
//
//  One transaction per clock while i_ready is high; 3 lookup stages,
//  2 multiply/sum stages, 8 divider stages, one quotient bit each.
//  Synchronous active-low reset clears valids and map_select (parula).
//  Each stage advances when empty or when the next one advances; a stalled
//  result holds in the last divider stage while bubbles upstream still fill.
//  Config is always ready; write it only with an empty pipeline (unchecked).
module colormap_interpolator_top
    import cmi_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_level,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_map_select
);

    localparam int DW = $clog2(LEVEL_COUNT);
    localparam int NW = DW + 10;
    localparam int TW = NW + 9;

    t_map_idx      r_map_select;

    logic          seg_valid, seg_ready;
    logic [NW-1:0] seg_num, seg_den;
    t_col_pair     seg_col;

    logic          mul_valid, mul_ready;
    logic [TW-1:0] mul_top [CH_COUNT];
    logic [NW-1:0] mul_den;

    t_rgb          div_rgb;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_select <= MAP_PARULA;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_map_select <= i_map_select;
        end
    end

    cmi_seg_select #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_level (i_level),
        .i_map   (r_map_select),
        .o_valid (seg_valid),
        .i_ready (seg_ready),
        .o_num   (seg_num),
        .o_den   (seg_den),
        .o_col   (seg_col)
    );

    cmi_lerp_mul #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_valid),
        .o_ready (seg_ready),
        .i_num   (seg_num),
        .i_den   (seg_den),
        .i_col   (seg_col),
        .o_valid (mul_valid),
        .i_ready (mul_ready),
        .o_top   (mul_top),
        .o_den   (mul_den)
    );

    cmi_div_pipe #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (mul_ready),
        .i_top   (mul_top),
        .i_den   (mul_den),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (div_rgb)
    );

    assign o_red   = div_rgb[CH_RED];
    assign o_green = div_rgb[CH_GREEN];
    assign o_blue  = div_rgb[CH_BLUE];

endmodule

### rtl/cmi_seg_select.sv
// Front stages: input register, segment search over the selected map, and
// interpolation fraction num/den with the stop colors. Depends on cmi_pkg.
module cmi_seg_select
    import cmi_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
    localparam int DW = $clog2(LEVEL_COUNT),
    localparam int NW = DW + 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  logic [7:0] i_level,
    input  t_map_idx  i_map,
    output logic      o_valid,
    input  logic      i_ready,
    output logic [NW-1:0] o_num,
    output logic [NW-1:0] o_den,
    output t_col_pair o_col
);

    localparam int D  = LEVEL_COUNT - 1;
    localparam int CW = (NW > 18) ? NW : 18;

    logic         adv_a, adv_b, adv_c;

    logic         r_a_v;
    logic [7:0]   r_a_level;
    t_map_idx     r_a_map;

    logic         r_b_v;
    logic [7:0]   r_b_level;
    t_map_idx     r_b_map;
    t_stop_idx    r_b_k;
    t_stop_idx    n_b_k;

    logic         r_c_v;
    logic [NW-1:0] r_c_num, r_c_den;
    logic [NW-1:0] n_c_num, n_c_den;
    t_col_pair    r_c_col, n_c_col;

    logic [CW-1:0] a_scaled, b_scaled, pa, pb, den_w;
    logic signed [CW:0] num_s;
    logic [7:0]   lvl_c;
    t_map_idx     map_c;

    assign adv_c   = !r_c_v || i_ready;
    assign adv_b   = !r_b_v || adv_c;
    assign adv_a   = !r_a_v || adv_b;
    assign o_ready = adv_a;

    // stage A: clamp level, fold unknown maps to parula
    assign lvl_c = (int'(i_level) > D) ? 8'(D) : i_level;
    assign map_c = (i_map >= t_map_idx'(MAP_COUNT)) ? MAP_PARULA : i_map;

    // stage B: segment = highest lower stop still below the level
    assign a_scaled = CW'(r_a_level) * CW'(POS_SCALE);

    always_comb begin
        n_b_k = '0;
        for (int j = 1; j < STOP_MAX - 1; j++) begin
            if ((j + 2 <= MAP_LEN[r_a_map]) &&
                (CW'(POS_ROM[r_a_map][j]) * CW'(D) < a_scaled)) begin
                n_b_k = t_stop_idx'(j);
            end
        end
    end

    // stage C: fraction and stop colors
    assign b_scaled = CW'(r_b_level) * CW'(POS_SCALE);
    assign pa       = CW'(POS_ROM[r_b_map][r_b_k]) * CW'(D);
    assign pb       = CW'(POS_ROM[r_b_map][r_b_k + 1'b1]) * CW'(D);
    assign den_w    = pb - pa;
    assign num_s    = $signed({1'b0, b_scaled}) - $signed({1'b0, pa});

    always_comb begin
        n_c_col.ca = stop_rgb(r_b_map, r_b_k);
        n_c_col.cb = stop_rgb(r_b_map, r_b_k + 1'b1);
        if (den_w == '0) begin
            n_c_den = NW'(1);
            n_c_num = '0;
        end else begin
            n_c_den = NW'(den_w);
            if (num_s < 0) begin
                n_c_num = '0;
            end else if (num_s > $signed({1'b0, den_w})) begin
                n_c_num = NW'(den_w);
            end else begin
                n_c_num = num_s[NW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_v <= i_valid;
            end
            if (adv_b) begin
                r_b_v <= r_a_v;
            end
            if (adv_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_level <= lvl_c;
            r_a_map   <= map_c;
        end
        if (adv_b) begin
            r_b_level <= r_a_level;
            r_b_map   <= r_a_map;
            r_b_k     <= n_b_k;
        end
        if (adv_c) begin
            r_c_num <= n_c_num;
            r_c_den <= n_c_den;
            r_c_col <= n_c_col;
        end
    end

    assign o_valid = r_c_v;
    assign o_num   = r_c_num;
    assign o_den   = r_c_den;
    assign o_col   = r_c_col;

endmodule

### rtl/cmi_lerp_mul.sv
// Middle stages: per-channel products and the rounded dividend
// 2*ca*den + 2*(cb-ca)*num + den. Depends on cmi_pkg.
module cmi_lerp_mul
    import cmi_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
    localparam int DW = $clog2(LEVEL_COUNT),
    localparam int NW = DW + 10,
    localparam int TW = NW + 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    input  t_col_pair     i_col,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [TW-1:0] o_top [CH_COUNT],
    output logic [NW-1:0] o_den
);

    localparam int P1W = NW + 8;
    localparam int P2W = NW + 10;
    localparam int SW  = NW + 12;

    logic adv_d, adv_e;

    logic                  r_d_v;
    logic [P1W-1:0]        r_d_p1 [CH_COUNT];
    logic signed [P2W-1:0] r_d_p2 [CH_COUNT];
    logic [NW-1:0]         r_d_den;
    logic [P1W-1:0]        n_d_p1 [CH_COUNT];
    logic signed [P2W-1:0] n_d_p2 [CH_COUNT];

    logic          r_e_v;
    logic [TW-1:0] r_e_top [CH_COUNT];
    logic [TW-1:0] n_e_top [CH_COUNT];
    logic [NW-1:0] r_e_den;

    assign adv_e   = !r_e_v || i_ready;
    assign adv_d   = !r_d_v || adv_e;
    assign o_ready = adv_d;

    always_comb begin
        logic signed [8:0] delta;
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            delta      = $signed({1'b0, i_col.cb[ch]}) - $signed({1'b0, i_col.ca[ch]});
            n_d_p1[ch] = P1W'(i_col.ca[ch]) * P1W'(i_den);
            n_d_p2[ch] = P2W'(delta) * P2W'($signed({1'b0, i_num}));
        end
    end

    // the sum is positive: interpolated value lies between the stop colors
    always_comb begin
        logic signed [SW-1:0] t1, t2, t3, sum;
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            t1          = SW'($signed({1'b0, r_d_p1[ch]}));
            t2          = SW'(r_d_p2[ch]);
            t3          = SW'($signed({1'b0, r_d_den}));
            sum         = (t1 <<< 1) + (t2 <<< 1) + t3;
            n_e_top[ch] = sum[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (adv_d) begin
                r_d_v <= i_valid;
            end
            if (adv_e) begin
                r_e_v <= r_d_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_d) begin
            r_d_p1  <= n_d_p1;
            r_d_p2  <= n_d_p2;
            r_d_den <= i_den;
        end
        if (adv_e) begin
            r_e_top <= n_e_top;
            r_e_den <= r_d_den;
        end
    end

    assign o_valid = r_e_v;
    assign o_top   = r_e_top;
    assign o_den   = r_e_den;

endmodule

### rtl/cmi_div_pipe.sv
// Restoring divider pipeline, one quotient bit per stage for all three
// channels, dividing the dividend by 2*den. Depends on cmi_pkg.
module cmi_div_pipe
    import cmi_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
    localparam int DW = $clog2(LEVEL_COUNT),
    localparam int NW = DW + 10,
    localparam int TW = NW + 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [TW-1:0] i_top [CH_COUNT],
    input  logic [NW-1:0] i_den,
    output logic          o_valid,
    input  logic          i_ready,
    output t_rgb          o_rgb
);

    localparam int LAST = QUO_BITS - 1;

    logic [QUO_BITS-1:0] adv;
    logic [QUO_BITS-1:0] v_in;
    logic [QUO_BITS-1:0] r_v;

    logic [TW-1:0] r_rem  [LAST][CH_COUNT];
    t_chan         r_q    [QUO_BITS][CH_COUNT];
    logic [NW:0]   r_div  [LAST];

    logic [TW-1:0] rem_in [QUO_BITS][CH_COUNT];
    t_chan         q_in   [QUO_BITS][CH_COUNT];
    logic [NW:0]   div_in [QUO_BITS];
    logic [TW-1:0] trial  [QUO_BITS];
    logic [TW-1:0] n_rem  [QUO_BITS][CH_COUNT];
    t_chan         n_q    [QUO_BITS][CH_COUNT];

    always_comb begin
        adv[LAST] = !r_v[LAST] || i_ready;
        for (int s = LAST - 1; s >= 0; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end
    end
    assign o_ready = adv[0];

    always_comb begin
        v_in[0]   = i_valid;
        div_in[0] = {i_den, 1'b0};
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            rem_in[0][ch] = i_top[ch];
            q_in[0][ch]   = '0;
        end
        for (int s = 1; s < QUO_BITS; s++) begin
            v_in[s]   = r_v[s-1];
            div_in[s] = r_div[s-1];
            for (int ch = 0; ch < CH_COUNT; ch++) begin
                rem_in[s][ch] = r_rem[s-1][ch];
                q_in[s][ch]   = r_q[s-1][ch];
            end
        end
    end

    always_comb begin
        for (int s = 0; s < QUO_BITS; s++) begin
            trial[s] = TW'(div_in[s]) << (LAST - s);
            for (int ch = 0; ch < CH_COUNT; ch++) begin
                if (rem_in[s][ch] >= trial[s]) begin
                    n_rem[s][ch] = rem_in[s][ch] - trial[s];
                    n_q[s][ch]   = q_in[s][ch] | (t_chan'(1) << (LAST - s));
                end else begin
                    n_rem[s][ch] = rem_in[s][ch];
                    n_q[s][ch]   = q_in[s][ch];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < QUO_BITS; s++) begin
                if (adv[s]) begin
                    r_v[s] <= v_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < QUO_BITS; s++) begin
            if (adv[s]) begin
                r_q[s] <= n_q[s];
            end
        end
        for (int s = 0; s < LAST; s++) begin
            if (adv[s]) begin
                r_rem[s] <= n_rem[s];
                r_div[s] <= div_in[s];
            end
        end
    end

    assign o_valid = r_v[LAST];

    always_comb begin
        for (int ch = 0; ch < CH_COUNT; ch++) begin
            o_rgb[ch] = r_q[LAST][ch];
        end
    end

endmodule

### rtl/cmi_checker.sv
// Port-level checker for colormap_interpolator_top, bound to the top level.
// Depends on cmi_pkg and colormap_interpolator_top_macros.svh.
`include "colormap_interpolator_top_macros.svh"

module cmi_checker
    import cmi_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    localparam int OW = $clog2(PIPE_DEPTH + 1);

    logic [OW-1:0] r_outstanding, n_outstanding;

    // transactions accepted but not yet delivered
    assign n_outstanding = r_outstanding + OW'(i_valid && o_ready) - OW'(o_valid && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    `CMI_ASSERT_IMPL(a_no_phantom, o_valid, r_outstanding != '0, "result without pending input")
    `CMI_ASSERT_IMPL(a_depth, 1'b1, r_outstanding <= OW'(PIPE_DEPTH), "pipeline overfilled")
    `CMI_ASSERT_IMPL(a_ready_empty, !o_valid, o_ready, "input stalled with no result waiting")
    `CMI_ASSERT_NEXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue), "stalled result changed")

endmodule

bind colormap_interpolator_top cmi_checker u_cmi_checker (.*);
